// ===== rtl/core/tcce_pkg.sv =====
package tcce_pkg;

  // Control codes acted on by the cursor engine
  localparam logic [7:0] CODE_BS    = 8'd8;
  localparam logic [7:0] CODE_TAB   = 8'd9;
  localparam logic [7:0] CODE_LF    = 8'd10;
  localparam logic [7:0] CODE_FF    = 8'd12;
  localparam logic [7:0] CODE_CR    = 8'd13;
  localparam logic [7:0] GLYPH_BLANK = 8'd32;

  // Result actions
  localparam logic ACT_DRAW  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  // Configuration register indexes
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_COLUMNS  = 2'd0;
  localparam reg_idx_t REG_ROWS     = 2'd1;
  localparam reg_idx_t REG_TAB_SIZE = 2'd2;

  // Microprogram addresses
  typedef logic [4:0] step_t;
  localparam step_t S_IDLE      = 5'd0;
  localparam step_t S_TST_CRLF  = 5'd1;
  localparam step_t S_TST_TAB   = 5'd2;
  localparam step_t S_TST_FF    = 5'd3;
  localparam step_t S_TST_BS    = 5'd4;
  localparam step_t S_PRINT     = 5'd5;
  localparam step_t S_CRLF      = 5'd6;
  localparam step_t S_TAB_INIT  = 5'd7;
  localparam step_t S_TAB_DIV   = 5'd8;
  localparam step_t S_TAB_SET   = 5'd9;
  localparam step_t S_FF        = 5'd10;
  localparam step_t S_BS        = 5'd11;
  localparam step_t S_WRAP      = 5'd12;
  localparam step_t S_ROWCHK    = 5'd13;
  localparam step_t S_EMIT_DRAW = 5'd14;
  localparam step_t S_EMIT_CLR  = 5'd15;
  localparam step_t S_EMIT_BLNK = 5'd16;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_DRAW_ADV,
    OP_NEWLINE,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_TAB_SET,
    OP_HOME,
    OP_BACK,
    OP_WRAP,
    OP_ROWCHK,
    OP_EMIT_DRAW,
    OP_EMIT_CLEAR,
    OP_EMIT_BLANK
  } op_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_CRLF,
    C_TAB,
    C_FF,
    C_BS,
    C_DIV_MORE
  } cond_t;

  typedef struct packed {
    logic  accept;
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic is_crlf;
    logic is_tab;
    logic is_ff;
    logic is_bs;
    logic div_more;
    logic stall;
  } stat_t;

  // Screen geometry with zero registers already forced to one
  typedef struct packed {
    logic [7:0] ncol;
    logic [7:0] nrow;
    logic [7:0] ntab;
  } geom_t;

  function automatic ctrl_t mk(logic acc, op_t op, cond_t cnd, step_t tgt);
    ctrl_t w;
    w.accept = acc;
    w.op     = op;
    w.cond   = cnd;
    w.target = tgt;
    return w;
  endfunction

  // Microcode store: one control word per step
  function automatic ctrl_t ucode_word(step_t step);
    ctrl_t w;
    case (step)
      S_IDLE:      w = mk(1'b1, OP_NOP,        C_NO_IN,    S_IDLE);
      S_TST_CRLF:  w = mk(1'b0, OP_NOP,        C_CRLF,     S_CRLF);
      S_TST_TAB:   w = mk(1'b0, OP_NOP,        C_TAB,      S_TAB_INIT);
      S_TST_FF:    w = mk(1'b0, OP_NOP,        C_FF,       S_FF);
      S_TST_BS:    w = mk(1'b0, OP_NOP,        C_BS,       S_BS);
      S_PRINT:     w = mk(1'b0, OP_DRAW_ADV,   C_ALWAYS,   S_WRAP);
      S_CRLF:      w = mk(1'b0, OP_NEWLINE,    C_ALWAYS,   S_WRAP);
      S_TAB_INIT:  w = mk(1'b0, OP_DIV_INIT,   C_NEVER,    S_IDLE);
      S_TAB_DIV:   w = mk(1'b0, OP_DIV_STEP,   C_DIV_MORE, S_TAB_DIV);
      S_TAB_SET:   w = mk(1'b0, OP_TAB_SET,    C_ALWAYS,   S_WRAP);
      S_FF:        w = mk(1'b0, OP_HOME,       C_ALWAYS,   S_WRAP);
      S_BS:        w = mk(1'b0, OP_BACK,       C_NEVER,    S_IDLE);
      S_WRAP:      w = mk(1'b0, OP_WRAP,       C_NEVER,    S_IDLE);
      S_ROWCHK:    w = mk(1'b0, OP_ROWCHK,     C_NEVER,    S_IDLE);
      S_EMIT_DRAW: w = mk(1'b0, OP_EMIT_DRAW,  C_NEVER,    S_IDLE);
      S_EMIT_CLR:  w = mk(1'b0, OP_EMIT_CLEAR, C_NEVER,    S_IDLE);
      S_EMIT_BLNK: w = mk(1'b0, OP_EMIT_BLANK, C_ALWAYS,   S_IDLE);
      default:     w = mk(1'b0, OP_NOP,        C_ALWAYS,   S_IDLE);
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/tcce_if.sv =====
interface tcce_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_write;
  modport source (output valid, char_code, end_of_write, input ready);
  modport sink   (input valid, char_code, end_of_write, output ready);
endinterface

interface tcce_out_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] cell_column;
  logic [7:0] cell_row;
  logic [7:0] glyph;
  logic       last;
  modport source (output valid, action, cell_column, cell_row, glyph, last, input ready);
  modport sink   (input valid, action, cell_column, cell_row, glyph, last, output ready);
endinterface

interface tcce_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/text_console_cursor_engine_unit.sv =====
// Text console cursor engine. Each input beat carries one character code; the
// block moves the cursor (CR/LF, tab, form feed, backspace, wrap, scroll-clear)
// and sends draw or clear-screen beats, at most three per character, in the
// order glyph draw, screen clear, cursor blank, with last set on the final one.
// A small microprogram steps through each character one control word a cycle
// when no result step is stalled; for tab, an 8-step restoring divider finds
// the column remainder modulo the tab size. Each result step waits while the
// output register still holds an untaken beat. Input is taken only at the idle
// step; configuration writes are always ready and should be made while no
// character is in flight. A columns, rows or tab size of zero acts as one.
module text_console_cursor_engine_unit
  import tcce_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  tcce_in_if.sink     in_bus,
  tcce_out_if.source  out_bus,
  tcce_cfg_if.sink    cfg_bus
);

  logic [7:0] columns_r, columns_nxt;
  logic [7:0] rows_r, rows_nxt;
  logic [7:0] tab_size_r, tab_size_nxt;
  geom_t      geom;
  ctrl_t      ctrl;
  stat_t      stat;

  assign cfg_bus.ready = 1'b1;

  // Register writes
  always_comb begin
    columns_nxt  = columns_r;
    rows_nxt     = rows_r;
    tab_size_nxt = tab_size_r;
    if (cfg_bus.valid) begin
      case (cfg_bus.index)
        REG_COLUMNS:  columns_nxt  = cfg_bus.data;
        REG_ROWS:     rows_nxt     = cfg_bus.data;
        REG_TAB_SIZE: tab_size_nxt = cfg_bus.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r  <= 8'd128;
      rows_r     <= 8'd96;
      tab_size_r <= 8'd8;
    end else begin
      columns_r  <= columns_nxt;
      rows_r     <= rows_nxt;
      tab_size_r <= tab_size_nxt;
    end
  end

  // Force zero settings to one
  always_comb begin
    geom.ncol = (columns_r == 8'd0) ? 8'd1 : columns_r;
    geom.nrow = (rows_r == 8'd0) ? 8'd1 : rows_r;
    geom.ntab = (tab_size_r == 8'd0) ? 8'd1 : tab_size_r;
  end

  tcce_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  tcce_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .geom    (geom),
    .ctrl    (ctrl),
    .stat    (stat),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

endmodule

// ===== rtl/core/tcce_sequencer.sv =====
module tcce_sequencer
  import tcce_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  stat_t stat,
  output ctrl_t ctrl
);

  step_t pc_r;
  step_t pc_nxt;
  logic  take;

  // Fetch the control word for the current step
  assign ctrl = ucode_word(pc_r);

  // Evaluate the jump condition
  always_comb begin
    case (ctrl.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_IN:    take = ~stat.in_valid;
      C_CRLF:     take = stat.is_crlf;
      C_TAB:      take = stat.is_tab;
      C_FF:       take = stat.is_ff;
      C_BS:       take = stat.is_bs;
      C_DIV_MORE: take = stat.div_more;
      default:    take = 1'b0;
    endcase
  end

  // Hold on a blocked emit, else jump or advance
  always_comb begin
    if (stat.stall) begin
      pc_nxt = pc_r;
    end else if (take) begin
      pc_nxt = ctrl.target;
    end else begin
      pc_nxt = pc_r + step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== rtl/core/tcce_datapath.sv =====
module tcce_datapath
  import tcce_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  geom_t             geom,
  input  ctrl_t             ctrl,
  output stat_t             stat,
  tcce_in_if.sink           in_bus,
  tcce_out_if.source        out_bus
);

  // Cursor, wide enough to hold an overflow before wrap
  logic [8:0] col_r, col_nxt;
  logic [8:0] row_r, row_nxt;
  // Current item
  logic [7:0] code_r, code_nxt;
  logic       end_r, end_nxt;
  logic       draw_r, draw_nxt;
  logic       clr_r, clr_nxt;
  // Draw position latched before the advance
  logic [7:0] dcol_r, dcol_nxt;
  logic [7:0] drow_r, drow_nxt;
  // Tab remainder divider
  logic [7:0] div_r, div_nxt;
  logic [7:0] rem_r, rem_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [8:0] rem_try;
  // Output register
  logic       ov_r, ov_nxt;
  logic       oact_r, oact_nxt;
  logic [7:0] ocol_r, ocol_nxt;
  logic [7:0] orow_r, orow_nxt;
  logic [7:0] oglyph_r, oglyph_nxt;
  logic       olast_r, olast_nxt;
  logic       emit_req;
  logic       emit_fire;
  logic       in_fire;

  assign in_bus.ready = ctrl.accept;
  assign in_fire      = in_bus.valid & ctrl.accept;

  assign out_bus.valid       = ov_r;
  assign out_bus.action      = oact_r;
  assign out_bus.cell_column = ocol_r;
  assign out_bus.cell_row    = orow_r;
  assign out_bus.glyph       = oglyph_r;
  assign out_bus.last        = olast_r;

  // Emit request when the step's result is due for this item
  always_comb begin
    case (ctrl.op)
      OP_EMIT_DRAW:  emit_req = draw_r;
      OP_EMIT_CLEAR: emit_req = clr_r;
      OP_EMIT_BLANK: emit_req = end_r;
      default:       emit_req = 1'b0;
    endcase
  end

  assign emit_fire = emit_req & (~ov_r | out_bus.ready);
  assign rem_try   = {rem_r, div_r[7]};

  // Status back to the sequencer
  always_comb begin
    stat.in_valid = in_bus.valid;
    stat.is_crlf  = (code_r == CODE_CR) || (code_r == CODE_LF);
    stat.is_tab   = (code_r == CODE_TAB);
    stat.is_ff    = (code_r == CODE_FF);
    stat.is_bs    = (code_r == CODE_BS);
    stat.div_more = (cnt_r != 3'd7);
    stat.stall    = emit_req & ov_r & ~out_bus.ready;
  end

  // Execute the control word
  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    code_nxt   = code_r;
    end_nxt    = end_r;
    draw_nxt   = draw_r;
    clr_nxt    = clr_r;
    dcol_nxt   = dcol_r;
    drow_nxt   = drow_r;
    div_nxt    = div_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    ov_nxt     = ov_r & ~out_bus.ready;
    oact_nxt   = oact_r;
    ocol_nxt   = ocol_r;
    orow_nxt   = orow_r;
    oglyph_nxt = oglyph_r;
    olast_nxt  = olast_r;

    // Take the new item
    if (in_fire) begin
      code_nxt = in_bus.char_code;
      end_nxt  = in_bus.end_of_write;
      draw_nxt = 1'b0;
      clr_nxt  = 1'b0;
    end

    case (ctrl.op)
      OP_DRAW_ADV: begin
        dcol_nxt = col_r[7:0];
        drow_nxt = row_r[7:0];
        draw_nxt = 1'b1;
        col_nxt  = col_r + 9'd1;
      end
      OP_NEWLINE: begin
        col_nxt = '0;
        row_nxt = row_r + 9'd1;
      end
      OP_DIV_INIT: begin
        div_nxt = col_r[7:0];
        rem_nxt = '0;
        cnt_nxt = '0;
      end
      OP_DIV_STEP: begin
        // One restoring division bit per step
        div_nxt = {div_r[6:0], 1'b0};
        if (rem_try >= {1'b0, geom.ntab}) begin
          rem_nxt = 8'(rem_try - {1'b0, geom.ntab});
        end else begin
          rem_nxt = rem_try[7:0];
        end
        cnt_nxt = cnt_r + 3'd1;
      end
      OP_TAB_SET: begin
        col_nxt = col_r - {1'b0, rem_r} + {1'b0, geom.ntab};
      end
      OP_HOME: begin
        col_nxt = '0;
        row_nxt = '0;
        clr_nxt = 1'b1;
      end
      OP_BACK: begin
        if (col_r != 9'd0) begin
          col_nxt = col_r - 9'd1;
        end else if (row_r != 9'd0) begin
          col_nxt = {1'b0, geom.ncol} - 9'd1;
          row_nxt = row_r - 9'd1;
        end
      end
      OP_WRAP: begin
        if (col_r >= {1'b0, geom.ncol}) begin
          col_nxt = '0;
          row_nxt = row_r + 9'd1;
        end
      end
      OP_ROWCHK: begin
        if (row_r >= {1'b0, geom.nrow}) begin
          col_nxt = '0;
          row_nxt = '0;
          clr_nxt = 1'b1;
        end
      end
      OP_EMIT_DRAW: begin
        oact_nxt   = ACT_DRAW;
        ocol_nxt   = dcol_r;
        orow_nxt   = drow_r;
        oglyph_nxt = code_r;
        olast_nxt  = ~clr_r & ~end_r;
      end
      OP_EMIT_CLEAR: begin
        oact_nxt   = ACT_CLEAR;
        ocol_nxt   = '0;
        orow_nxt   = '0;
        oglyph_nxt = '0;
        olast_nxt  = ~end_r;
      end
      OP_EMIT_BLANK: begin
        oact_nxt   = ACT_DRAW;
        ocol_nxt   = col_r[7:0];
        orow_nxt   = row_r[7:0];
        oglyph_nxt = GLYPH_BLANK;
        olast_nxt  = 1'b1;
      end
      default: begin
      end
    endcase

    // Load the output beat only when the register frees up
    if (!emit_fire) begin
      oact_nxt   = oact_r;
      ocol_nxt   = ocol_r;
      orow_nxt   = orow_r;
      oglyph_nxt = oglyph_r;
      olast_nxt  = olast_r;
    end else begin
      ov_nxt = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      ov_r   <= 1'b0;
      draw_r <= 1'b0;
      clr_r  <= 1'b0;
      end_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      ov_r   <= ov_nxt;
      draw_r <= draw_nxt;
      clr_r  <= clr_nxt;
      end_r  <= end_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    code_r   <= code_nxt;
    dcol_r   <= dcol_nxt;
    drow_r   <= drow_nxt;
    div_r    <= div_nxt;
    rem_r    <= rem_nxt;
    oact_r   <= oact_nxt;
    ocol_r   <= ocol_nxt;
    orow_r   <= orow_nxt;
    oglyph_r <= oglyph_nxt;
    olast_r  <= olast_nxt;
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import tcce_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 4000;
  localparam int RAND_CHUNKS   = 6;
  localparam int CHUNK_CHARS   = 70;
  localparam int PRINT_CAP     = 30;

  typedef struct packed {
    logic [7:0] code;
    logic       eow;
  } char_beat_t;

  typedef struct packed {
    logic       action;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] glyph;
    logic       last;
  } screen_op_t;

  logic clk = 1'b0;
  logic rst_n;

  tcce_in_if  in_bus();
  tcce_out_if out_bus();
  tcce_cfg_if cfg_bus();

  text_console_cursor_engine_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  // Characters waiting to be sent and screen operations still owed
  char_beat_t char_q[$];
  screen_op_t screen_ops_q[$];

  // Shadow geometry and cursor
  logic [7:0] geom_cols;
  logic [7:0] geom_rows;
  logic [7:0] geom_tab;
  logic [7:0] cur_col;
  logic [7:0] cur_row;

  int err_count;
  int quiet_cycles;
  int tx_idle_pct;
  int rx_idle_pct;
  char_beat_t next_char;
  screen_op_t got_op;

  // Clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(string msg);
    if (err_count < PRINT_CAP)
      $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_field(string field, logic [7:0] exp_v, logic [7:0] got_v);
    if (exp_v !== got_v)
      report_mismatch($sformatf("%s expected %0d got %0d", field, exp_v, got_v));
  endtask

  function automatic screen_op_t mk_op(logic act, int unsigned c, int unsigned r,
                                       logic [7:0] g);
    screen_op_t op;
    op.action = act;
    op.col    = c[7:0];
    op.row    = r[7:0];
    op.glyph  = g;
    op.last   = 1'b0;
    return op;
  endfunction

  // Move the shadow cursor for one character and queue the screen operations it causes
  function automatic void advance_cursor(logic [7:0] code, logic eow);
    int unsigned ncol, nrow, ntab, c, r;
    screen_op_t ops[$];
    screen_op_t op;
    ncol = (geom_cols == 8'd0) ? 1 : geom_cols;
    nrow = (geom_rows == 8'd0) ? 1 : geom_rows;
    ntab = (geom_tab == 8'd0) ? 1 : geom_tab;
    c = cur_col;
    r = cur_row;
    case (code)
      CODE_CR, CODE_LF: begin
        c = 0;
        r = r + 1;
      end
      CODE_TAB: begin
        c = (c / ntab) * ntab + ntab;
      end
      CODE_FF: begin
        c = 0;
        r = 0;
        ops.push_back(mk_op(ACT_CLEAR, 0, 0, 8'd0));
      end
      CODE_BS: begin
        if (c > 0) begin
          c = c - 1;
        end else if (r > 0) begin
          c = ncol - 1;
          r = r - 1;
        end
      end
      default: begin
        ops.push_back(mk_op(ACT_DRAW, c, r, code));
        c = c + 1;
      end
    endcase
    // Wrap the column, then clear and home on row overflow
    if (c >= ncol) begin
      c = 0;
      r = r + 1;
    end
    if (r >= nrow) begin
      c = 0;
      r = 0;
      ops.push_back(mk_op(ACT_CLEAR, 0, 0, 8'd0));
    end
    cur_col = c[7:0];
    cur_row = r[7:0];
    if (eow)
      ops.push_back(mk_op(ACT_DRAW, cur_col, cur_row, GLYPH_BLANK));
    for (int i = 0; i < ops.size(); i++) begin
      op = ops[i];
      op.last = (i == ops.size() - 1);
      screen_ops_q.push_back(op);
    end
  endfunction

  // Driver: present the next character once the current beat is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid        <= 1'b0;
      in_bus.char_code    <= 8'd0;
      in_bus.end_of_write <= 1'b0;
    end else if (!in_bus.valid || in_bus.ready) begin
      if (char_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        next_char = char_q.pop_front();
        in_bus.valid        <= 1'b1;
        in_bus.char_code    <= next_char.code;
        in_bus.end_of_write <= next_char.eow;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Monitor: track config and input beats, check result beats, drive ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      geom_cols    = 8'd128;
      geom_rows    = 8'd96;
      geom_tab     = 8'd8;
      cur_col      = 8'd0;
      cur_row      = 8'd0;
      quiet_cycles = 0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
      quiet_cycles++;

      if (cfg_bus.valid && cfg_bus.ready) begin
        quiet_cycles = 0;
        case (cfg_bus.index)
          REG_COLUMNS:  geom_cols = cfg_bus.data;
          REG_ROWS:     geom_rows = cfg_bus.data;
          REG_TAB_SIZE: geom_tab  = cfg_bus.data;
          default: ;
        endcase
      end

      if (out_bus.valid && out_bus.ready) begin
        quiet_cycles = 0;
        if (screen_ops_q.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          got_op = screen_ops_q.pop_front();
          check_field("action", {7'd0, got_op.action}, {7'd0, out_bus.action});
          check_field("cell_column", got_op.col, out_bus.cell_column);
          check_field("cell_row", got_op.row, out_bus.cell_row);
          check_field("glyph", got_op.glyph, out_bus.glyph);
          check_field("last", {7'd0, got_op.last}, {7'd0, out_bus.last});
        end
      end

      if (in_bus.valid && in_bus.ready) begin
        quiet_cycles = 0;
        advance_cursor(in_bus.char_code, in_bus.end_of_write);
      end

      // Watchdog
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TIMEOUT: no beat for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic push_char(logic [7:0] code, logic eow);
    char_beat_t b;
    b.code = code;
    b.eow  = eow;
    char_q.push_back(b);
  endtask

  // Hold until every character is sent and every result is back, then let the engine settle
  task automatic drain();
    while (char_q.size() > 0 || in_bus.valid || screen_ops_q.size() > 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [7:0] val);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic set_geometry(logic [7:0] c, logic [7:0] r, logic [7:0] t);
    write_reg(REG_COLUMNS, c);
    write_reg(REG_ROWS, r);
    write_reg(REG_TAB_SIZE, t);
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_dim();
    case ($urandom_range(9))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd255;
      3, 4, 5: return 8'($urandom_range(6, 2));
      default: return 8'($urandom_range(255, 1));
    endcase
  endfunction

  function automatic logic [7:0] pick_char();
    if ($urandom_range(99) < 55)
      return 8'($urandom_range(255));
    case ($urandom_range(4))
      0:       return CODE_CR;
      1:       return CODE_LF;
      2:       return CODE_TAB;
      3:       return CODE_FF;
      default: return CODE_BS;
    endcase
  endfunction

  // Stimulus sequence
  initial begin
    rst_n               = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.char_code    = 8'd0;
    in_bus.end_of_write = 1'b0;
    out_bus.ready       = 1'b0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.index       = REG_COLUMNS;
    cfg_bus.data        = 8'd0;
    err_count           = 0;
    tx_idle_pct         = 16;
    rx_idle_pct         = 57;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset geometry: backspace at home, code extremes, every control code
    push_char(CODE_BS, 1'b1);
    push_char(8'd65, 1'b0);
    push_char(8'd0, 1'b0);
    push_char(8'd255, 1'b1);
    push_char(CODE_TAB, 1'b1);
    push_char(CODE_CR, 1'b0);
    push_char(CODE_LF, 1'b1);
    push_char(CODE_BS, 1'b1);
    push_char(CODE_FF, 1'b1);
    drain();

    // Tiny screen: wrap, backspace onto the previous row, tab wrap, scroll clear
    set_geometry(8'd3, 8'd2, 8'd2);
    push_char(8'd120, 1'b0);
    push_char(8'd121, 1'b0);
    push_char(8'd122, 1'b0);
    push_char(CODE_BS, 1'b1);
    push_char(CODE_TAB, 1'b0);
    push_char(CODE_TAB, 1'b1);
    push_char(CODE_LF, 1'b0);
    drain();

    // Zero registers behave as one
    set_geometry(8'd0, 8'd0, 8'd0);
    push_char(8'd97, 1'b1);
    push_char(CODE_TAB, 1'b1);
    push_char(CODE_BS, 1'b1);
    drain();

    // Park the cursor far right, then shrink the screen under it
    set_geometry(8'd255, 8'd255, 8'd200);
    push_char(8'd98, 1'b0);
    push_char(CODE_TAB, 1'b1);
    drain();
    set_geometry(8'd10, 8'd4, 8'd7);
    push_char(8'd99, 1'b1);
    push_char(CODE_BS, 1'b1);
    drain();

    // Random chunks: sender-light, receiver-light, then no idling
    for (int k = 0; k < RAND_CHUNKS; k++) begin
      case (k / 2)
        0: begin
          tx_idle_pct = 16;
          rx_idle_pct = 57;
        end
        1: begin
          tx_idle_pct = 57;
          rx_idle_pct = 16;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      set_geometry(pick_dim(), pick_dim(), pick_dim());
      repeat (CHUNK_CHARS) push_char(pick_char(), ($urandom_range(99) < 30));
      drain();
    end

    if (screen_ops_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", screen_ops_q.size()));
    if (err_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/tcce_pkg.sv
rtl/core/tcce_if.sv
rtl/core/tcce_sequencer.sv
rtl/core/tcce_datapath.sv
rtl/core/text_console_cursor_engine_unit.sv
tb/sv/testbench.sv
